// ----- design/rsakl_pkg.sv -----
`default_nettype none
package rsakl_pkg;

  localparam int BUF_DEPTH = 65536;
  localparam int LOOKBACK  = 5;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int FILL_W    = ADDR_W + 1;
  localparam int HP_W      = 34;
  localparam int D_W       = $clog2(LOOKBACK + 2);

  localparam logic [7:0]  SEQ_TAG        = 8'h30;
  localparam logic [7:0]  INT_TAG        = 8'h02;
  localparam logic [31:0] MAX_LEN_RESET  = 32'd26000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [15:0] key_offset;
  } out_word_t;

  typedef enum logic [2:0] {
    SEL_MARK,
    SEL_LOOK,
    SEL_HDR,
    SEL_LEN,
    SEL_VAL
  } rd_sel_t;

  typedef enum logic [4:0] {
    S_LOAD, S_START, S_CAND, S_MRD, S_MEV, S_LOOK, S_LEV,
    S_HRD, S_HEV, S_LCHK, S_LBEV, S_HCHK, S_VEV, S_FOUND, S_NOTF
  } state_t;

  typedef struct packed {
    logic    we;
    logic    scan_init;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    m_clr;
    logic    m_inc;
    logic    pos_inc;
    logic    d_init;
    logic    d_inc;
    logic    hp_from_k;
    logic    hdr_short;
    logic    len_start;
    logic    len_shift;
    logic    len_done;
    logic    hp_add_fl;
    logic    hdr_inc;
    logic    out_load;
    logic    out_found;
  } cmd_t;

  typedef struct packed {
    logic       len_lt4;
    logic       scan_end;
    logic       rd_ok;
    logic       match;
    logic       m_last;
    logic       look_end;
    logic       is_seq;
    logic       is_int;
    logic       long_form;
    logic       j_end;
    logic       len_ok;
    logic [1:0] hdr_idx;
    logic       out_busy;
  } stat_t;

  function automatic logic [7:0] marker(input logic [1:0] m);
    unique case (m)
      2'd0: marker = 8'h02;
      2'd1: marker = 8'h01;
      2'd2: marker = 8'h00;
      default: marker = 8'h02;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- design/rsakl_ctrl.sv -----
`default_nettype none
module rsakl_ctrl import rsakl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_fire,
  input  wire logic  in_last,
  input  wire stat_t st,
  output logic       busy,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:  if (in_fire && in_last) state_next = S_START;
      S_START: state_next = st.len_lt4 ? S_NOTF : S_CAND;
      S_CAND:  state_next = st.scan_end ? S_NOTF : S_MRD;
      S_MRD:   state_next = S_MEV;
      S_MEV: begin
        if (!st.match)      state_next = S_CAND;
        else if (st.m_last) state_next = S_LOOK;
        else                state_next = S_MRD;
      end
      S_LOOK:  state_next = st.look_end ? S_CAND : S_LEV;
      S_LEV:   state_next = (st.rd_ok && st.is_seq) ? S_HRD : S_LOOK;
      S_HRD:   state_next = S_HEV;
      S_HEV: begin
        if (!st.rd_ok)         state_next = S_CAND;
        else if (st.long_form) state_next = S_LCHK;
        else                   state_next = S_HCHK;
      end
      S_LCHK:  state_next = st.j_end ? S_HCHK : S_LBEV;
      S_LBEV:  state_next = st.rd_ok ? S_LCHK : S_CAND;
      S_HCHK: begin
        unique case (st.hdr_idx)
          2'd0:    state_next = st.len_ok ? S_HRD : S_CAND;
          2'd1:    state_next = S_VEV;
          default: state_next = st.len_ok ? S_FOUND : S_CAND;
        endcase
      end
      S_VEV:   state_next = (st.rd_ok && st.is_int && st.len_ok) ? S_HRD : S_CAND;
      S_FOUND: if (!st.out_busy) state_next = S_LOAD;
      S_NOTF:  if (!st.out_busy) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    cmd  = '0;
    cmd.rd_sel = SEL_MARK;
    busy = (state != S_LOAD);
    unique case (state)
      S_LOAD:  cmd.we = in_fire;
      S_START: cmd.scan_init = 1'b1;
      S_CAND:  cmd.m_clr = 1'b1;
      S_MRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_MARK;
      end
      S_MEV: begin
        if (!st.match)      cmd.pos_inc = 1'b1;
        else if (st.m_last) cmd.d_init = 1'b1;
        else                cmd.m_inc = 1'b1;
      end
      S_LOOK: begin
        if (st.look_end) cmd.pos_inc = 1'b1;
        else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = SEL_LOOK;
        end
      end
      S_LEV: begin
        if (st.rd_ok && st.is_seq) cmd.hp_from_k = 1'b1;
        else                       cmd.d_inc = 1'b1;
      end
      S_HRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_HDR;
      end
      S_HEV: begin
        if (!st.rd_ok)         cmd.pos_inc = 1'b1;
        else if (st.long_form) cmd.len_start = 1'b1;
        else                   cmd.hdr_short = 1'b1;
      end
      S_LCHK: begin
        if (st.j_end) cmd.len_done = 1'b1;
        else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = SEL_LEN;
        end
      end
      S_LBEV: begin
        if (st.rd_ok) cmd.len_shift = 1'b1;
        else          cmd.pos_inc = 1'b1;
      end
      S_HCHK: begin
        unique case (st.hdr_idx)
          2'd0: begin
            if (st.len_ok) cmd.hdr_inc = 1'b1;
            else           cmd.pos_inc = 1'b1;
          end
          2'd1: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_VAL;
          end
          default: if (!st.len_ok) cmd.pos_inc = 1'b1;
        endcase
      end
      S_VEV: begin
        if (st.rd_ok && st.is_int && st.len_ok) begin
          cmd.hp_add_fl = 1'b1;
          cmd.hdr_inc   = 1'b1;
        end else cmd.pos_inc = 1'b1;
      end
      S_FOUND: begin
        cmd.out_load  = !st.out_busy;
        cmd.out_found = 1'b1;
      end
      S_NOTF:  cmd.out_load = !st.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/rsakl_dp.sv -----
`default_nettype none
module rsakl_dp import rsakl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire in_word_t    in_word,
  input  wire logic        cfg_fire,
  input  wire logic [31:0] cfg_data,
  input  wire logic        out_stall,
  output stat_t            st,
  output logic             out_valid,
  output out_word_t        out_word
);

  logic [7:0]        mem [BUF_DEPTH];
  logic [31:0]       max_len;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] pos;
  logic [1:0]        m;
  logic [D_W-1:0]    d;
  logic [HP_W-1:0]   hp;
  logic [31:0]       fl;
  logic [6:0]        n;
  logic [6:0]        j;
  logic [1:0]        hdr;
  logic [15:0]       key;
  logic [7:0]        rdata;
  logic              rd_ok;
  logic [HP_W-1:0]   addr;
  logic [FILL_W-1:0] look_addr;

  assign look_addr = pos - FILL_W'(d);

  always_comb begin
    unique case (cmd.rd_sel)
      SEL_MARK: addr = HP_W'(pos) + HP_W'(m);
      SEL_LOOK: addr = HP_W'(look_addr);
      SEL_HDR:  addr = hp + HP_W'(1);
      SEL_LEN:  addr = hp + HP_W'(2) + HP_W'(j);
      default:  addr = hp + HP_W'(fl);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we && fill < FILL_W'(BUF_DEPTH)) mem[fill[ADDR_W-1:0]] <= in_word.data_byte;
    if (cmd.rd_en) rdata <= mem[addr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len   <= MAX_LEN_RESET;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_fire) max_len <= cfg_data;
      if (cmd.we && fill < FILL_W'(BUF_DEPTH)) fill <= fill + FILL_W'(1);
      if (cmd.out_load) begin
        fill      <= '0;
        out_valid <= 1'b1;
      end else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en)     rd_ok <= addr < HP_W'(fill);
    if (cmd.scan_init) pos <= FILL_W'(2);
    if (cmd.pos_inc)   pos <= pos + FILL_W'(1);
    if (cmd.m_clr)     m <= '0;
    if (cmd.m_inc)     m <= m + 2'd1;
    if (cmd.d_init)    d <= D_W'(2);
    if (cmd.d_inc)     d <= d + D_W'(1);
    if (cmd.hp_from_k) begin
      hp  <= HP_W'(look_addr);
      key <= look_addr[15:0];
      hdr <= '0;
    end
    if (cmd.hdr_short) begin
      fl <= 32'(rdata);
      hp <= hp + HP_W'(2);
    end
    if (cmd.len_start) begin
      n  <= rdata[6:0];
      j  <= '0;
      fl <= '0;
    end
    if (cmd.len_shift) begin
      fl <= {fl[23:0], rdata};
      j  <= j + 7'd1;
    end
    if (cmd.len_done)  hp <= hp + HP_W'(2) + HP_W'(n);
    if (cmd.hp_add_fl) hp <= hp + HP_W'(fl);
    if (cmd.hdr_inc)   hdr <= hdr + 2'd1;
    if (cmd.out_load) begin
      out_word.found      <= cmd.out_found;
      out_word.key_offset <= cmd.out_found ? key : 16'd0;
    end
  end

  always_comb begin
    st.len_lt4   = fill < FILL_W'(4);
    st.scan_end  = (FILL_W + 1)'(pos) + (FILL_W + 1)'(4) >= (FILL_W + 1)'(fill);
    st.rd_ok     = rd_ok;
    st.match     = rdata == marker(m);
    st.m_last    = m == 2'd3;
    st.look_end  = (d > D_W'(LOOKBACK)) || (FILL_W'(d) > pos);
    st.is_seq    = rdata == SEQ_TAG;
    st.is_int    = rdata == INT_TAG;
    st.long_form = rdata[7];
    st.j_end     = j == n;
    st.len_ok    = (fl != 32'd0) && (fl <= max_len);
    st.hdr_idx   = hdr;
    st.out_busy  = out_valid;
  end

  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid) else $error("result loaded over pending one");
  a_look_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && cmd.rd_sel == SEL_LOOK) |-> (FILL_W'(d) <= pos))
    else $error("lookback below zero");
  a_tag_inside: assert property (@(posedge clk) disable iff (rst)
    cmd.hp_from_k |=> (hp < HP_W'(fill))) else $error("tag outside image");

endmodule
`default_nettype wire

// ----- design/rsa_private_key_locator_core.sv -----
`default_nettype none
// Loads an image one byte per accepted word (one per cycle) into a 64 KiB
// single-port buffer, then on the last byte scans it for an RSA key header
// and returns one word: found and the offset of the sequence tag. The scan
// does one buffer read at a time and evaluates each read before it issues the next;
// a start position that misses on its first byte is dropped at once and the
// scan moves on to the next position. Input stalls during scan.
module rsa_private_key_locator_core import rsakl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;
  logic  busy;

  assign in_stall  = busy;
  assign cfg_ready = 1'b1;

  rsakl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_valid && !busy),
    .in_last (in_word.last_byte),
    .st      (st),
    .busy    (busy),
    .cmd     (cmd)
  );

  rsakl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_word   (in_word),
    .cfg_fire  (cfg_valid),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .st        (st),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire
